### rtl/tehq_pkg.sv
package tehq_pkg;

  localparam int unsigned TICK_W   = 16;
  localparam int unsigned TMO_W    = 15;
  localparam int unsigned STATUS_W = 3;

  // operation codes
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_ENQ   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DEQ   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

  // ordering key of a heap entry, laid out as the top bits of a stored entry
  typedef struct packed {
    logic [TMO_W-1:0]  timeout;
    logic [TICK_W-1:0] created;
  } key_t;

endpackage

### rtl/tehq_heap_ram.sv
module tehq_heap_ram #(
  parameter int unsigned Depth  = 16,
  parameter int unsigned EntryW = 39,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AddrW-1:0]  waddr_i,
  input  logic [EntryW-1:0] wdata_i,
  input  logic [AddrW-1:0]  raddr_i,
  output logic [EntryW-1:0] rdata_o
);

  logic [EntryW-1:0] mem_q [Depth];
  logic [EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/tehq_urgency_cmp.sv
module tehq_urgency_cmp
  import tehq_pkg::*;
(
  input  logic [TICK_W-1:0] now_i,
  input  key_t              a_i,
  input  key_t              b_i,
  output logic              a_sooner_o
);

  localparam int unsigned UrgW = TICK_W + 2;

  logic [TICK_W-1:0]      passed_a, passed_b;
  logic signed [UrgW-1:0] urg_a, urg_b;

  // elapsed ticks wrap at the timer width
  assign passed_a = now_i - a_i.created;
  assign passed_b = now_i - b_i.created;

  // urgency = elapsed - 2 * timeout, larger is due sooner
  assign urg_a = $signed({2'b00, passed_a}) - $signed({2'b00, a_i.timeout, 1'b0});
  assign urg_b = $signed({2'b00, passed_b}) - $signed({2'b00, b_i.timeout, 1'b0});

  assign a_sooner_o = urg_a > urg_b;

endmodule

### rtl/timer_event_heap_queue_core.sv
// channel   | ports                                              | transfer
// ----------+----------------------------------------------------+---------------------------
// command   | operation_i now_ticks_i timeout_us_i event_tag_i   | start high while busy low
// result    | status_o out_tag_o out_timeout_o out_created_o     | done_o high for one cycle
//           | out_count_o                                        |
//
// a rejected or empty command answers in the cycle after its transfer
// enqueue: carries the new entry up from the end, reading and comparing the parent at each
// heap level; dequeue: reads the root and ends when it takes the last entry, else loads the
// last entry and descends, reading the left and, if present, the right child at each level;
// heap reads share the one registered read port of the entry memory and one urgency comparator
// reset clears the entry count and the sequencer, entry contents stay unknown
// the receiver cannot stall; busy stays high until the result strobe
module timer_event_heap_queue_core
  import tehq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned TAG_BITS = 8,
  localparam int unsigned CntW = $clog2(CAPACITY + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                operation_i,
  input  logic [TICK_W-1:0]   now_ticks_i,
  input  logic [TMO_W-1:0]    timeout_us_i,
  input  logic [TAG_BITS-1:0] event_tag_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [TAG_BITS-1:0] out_tag_o,
  output logic [TMO_W-1:0]    out_timeout_o,
  output logic [TICK_W-1:0]   out_created_o,
  output logic [CntW-1:0]     out_count_o
);

  localparam int unsigned AddrW  = $clog2(CAPACITY);
  localparam int unsigned EntryW = TMO_W + TICK_W + TAG_BITS;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_UP_RD   = 4'd1;
  localparam logic [3:0] S_UP_CMP  = 4'd2;
  localparam logic [3:0] S_DQ_ROOT = 4'd3;
  localparam logic [3:0] S_DQ_LAST = 4'd4;
  localparam logic [3:0] S_DQ_LOAD = 4'd5;
  localparam logic [3:0] S_DN_RDL  = 4'd6;
  localparam logic [3:0] S_DN_RDR  = 4'd7;
  localparam logic [3:0] S_DN_CMPR = 4'd8;

  logic [3:0]          state_q, state_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     idx_q, idx_d;
  logic [CntW-1:0]     best_idx_q, best_idx_d;
  logic [EntryW-1:0]   hole_q, hole_d;
  logic [EntryW-1:0]   best_q, best_d;
  logic [TICK_W-1:0]   now_q, now_d;
  logic                done_q, done_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [TAG_BITS-1:0] tag_q, tag_d;
  logic [TMO_W-1:0]    tmo_q, tmo_d;
  logic [TICK_W-1:0]   cre_q, cre_d;

  logic              ram_we;
  logic [AddrW-1:0]  ram_waddr, ram_raddr;
  logic [EntryW-1:0] ram_wdata, ram_rdata;

  key_t cmp_a, cmp_b;
  logic a_sooner;

  logic [CntW-1:0]   parent_idx;
  logic [CntW:0]     left_idx, right_idx;
  logic              left_ok, right_ok;
  logic [CntW-1:0]   cand_idx;
  logic [EntryW-1:0] cand_ent;

  tehq_heap_ram #(
    .Depth  (CAPACITY),
    .EntryW (EntryW)
  ) u_heap_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  tehq_urgency_cmp u_urgency_cmp (
    .now_i      (now_q),
    .a_i        (cmp_a),
    .b_i        (cmp_b),
    .a_sooner_o (a_sooner)
  );

  assign parent_idx = (idx_q - CntW'(1)) >> 1;
  assign left_idx   = {idx_q, 1'b1};
  assign right_idx  = left_idx + (CntW + 1)'(1);
  assign left_ok    = left_idx < {1'b0, count_q};
  assign right_ok   = right_idx < {1'b0, count_q};

  // best of the children seen so far against the carried entry
  always_comb begin
    cand_idx = idx_q;
    cand_ent = hole_q;
    if (state_q == S_DN_RDR) begin
      if (a_sooner) begin
        cand_idx = left_idx[CntW-1:0];
        cand_ent = ram_rdata;
      end
    end else begin
      if (a_sooner) begin
        cand_idx = right_idx[CntW-1:0];
        cand_ent = ram_rdata;
      end else begin
        cand_idx = best_idx_q;
        cand_ent = best_q;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    best_idx_d = best_idx_q;
    hole_d     = hole_q;
    best_d     = best_q;
    now_d      = now_q;
    done_d     = 1'b0;
    status_d   = status_q;
    tag_d      = tag_q;
    tmo_d      = tmo_q;
    cre_d      = cre_q;
    ram_we     = 1'b0;
    ram_waddr  = idx_q[AddrW-1:0];
    ram_wdata  = hole_q;
    ram_raddr  = '0;
    cmp_a      = key_t'(ram_rdata[EntryW-1:TAG_BITS]);
    cmp_b      = key_t'(hole_q[EntryW-1:TAG_BITS]);

    case (state_q)
      S_IDLE: begin
        if (start) begin
          now_d = now_ticks_i;
          tag_d = '0;
          tmo_d = '0;
          cre_d = '0;
          if (operation_i == OP_ENQ) begin
            if (count_q == CntW'(CAPACITY)) begin
              status_d = ST_FULL;
              done_d   = 1'b1;
            end else if (timeout_us_i == '0) begin
              status_d = ST_ZERO;
              done_d   = 1'b1;
            end else begin
              status_d = ST_ENQ;
              hole_d   = {timeout_us_i, now_ticks_i, event_tag_i};
              idx_d    = count_q;
              count_d  = count_q + CntW'(1);
              state_d  = S_UP_RD;
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              done_d   = 1'b1;
            end else begin
              status_d = ST_DEQ;
              count_d  = count_q - CntW'(1);
              state_d  = S_DQ_ROOT;
            end
          end
        end
      end
      S_UP_RD: begin
        if (idx_q == '0) begin
          ram_we  = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ram_raddr = parent_idx[AddrW-1:0];
          state_d   = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmp_a  = key_t'(hole_q[EntryW-1:TAG_BITS]);
        cmp_b  = key_t'(ram_rdata[EntryW-1:TAG_BITS]);
        ram_we = 1'b1;
        if (a_sooner) begin
          // parent moves down into the hole
          ram_wdata = ram_rdata;
          idx_d     = parent_idx;
          state_d   = S_UP_RD;
        end else begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DQ_ROOT: begin
        ram_raddr = '0;
        state_d   = S_DQ_LAST;
      end
      S_DQ_LAST: begin
        tmo_d = ram_rdata[EntryW-1 -: TMO_W];
        cre_d = ram_rdata[TAG_BITS +: TICK_W];
        tag_d = ram_rdata[TAG_BITS-1:0];
        if (count_q == '0) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          ram_raddr = count_q[AddrW-1:0];
          state_d   = S_DQ_LOAD;
        end
      end
      S_DQ_LOAD: begin
        hole_d  = ram_rdata;
        idx_d   = '0;
        state_d = S_DN_RDL;
      end
      S_DN_RDL: begin
        if (left_ok) begin
          ram_raddr = left_idx[AddrW-1:0];
          state_d   = S_DN_RDR;
        end else begin
          ram_we  = 1'b1;
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_DN_RDR, S_DN_CMPR: begin
        if (state_q == S_DN_CMPR) begin
          cmp_b = key_t'(best_q[EntryW-1:TAG_BITS]);
        end
        if (state_q == S_DN_RDR && right_ok) begin
          best_idx_d = cand_idx;
          best_d     = cand_ent;
          ram_raddr  = right_idx[AddrW-1:0];
          state_d    = S_DN_CMPR;
        end else begin
          ram_we = 1'b1;
          if (cand_idx == idx_q) begin
            done_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            // winning child moves up into the hole
            ram_wdata = cand_ent;
            idx_d     = cand_idx;
            state_d   = S_DN_RDL;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    best_idx_q <= best_idx_d;
    hole_q     <= hole_d;
    best_q     <= best_d;
    now_q      <= now_d;
    status_q   <= status_d;
    tag_q      <= tag_d;
    tmo_q      <= tmo_d;
    cre_q      <= cre_d;
  end

  assign busy          = state_q != S_IDLE;
  assign done_o        = done_q;
  assign status_o      = status_q;
  assign out_tag_o     = tag_q;
  assign out_timeout_o = tmo_q;
  assign out_created_o = cre_q;
  assign out_count_o   = count_q;

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while sequencer still busy");

  a_transfer_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted command neither answered nor in progress");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && operation_i == OP_ENQ && count_q == CntW'(CAPACITY))
      |=> (done_o && status_o == ST_FULL && $stable(count_q)))
    else $error("enqueue into full heap not rejected");

endmodule

### tb/tb_timer_event_heap_queue_core.sv
`timescale 1ns / 1ps

module tb_timer_event_heap_queue_core;
  import tehq_pkg::*;

  localparam int unsigned Capacity   = 16;
  localparam int unsigned TagBits    = 8;
  localparam int unsigned CntW       = $clog2(Capacity + 1);
  localparam int unsigned RandomCmds = 1000;
  localparam int unsigned PhaseLen   = 40;
  localparam int unsigned DrainWait  = 40;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [TMO_W-1:0]   timeout;
    logic [TICK_W-1:0]  created;
    logic [TagBits-1:0] tag;
  } heap_slot_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TagBits-1:0]  tag;
    logic [TMO_W-1:0]    timeout;
    logic [TICK_W-1:0]   created;
    logic [CntW-1:0]     count;
  } answer_t;

  // mirror of the event heap, predicts the answer of every accepted command
  class timer_heap_tracker;
    heap_slot_t  slots[Capacity];
    int unsigned occupancy;
    answer_t     expected_answers[$];
    int unsigned mismatches;
    int unsigned status_tally[5];

    function new();
      occupancy  = 0;
      mismatches = 0;
      foreach (status_tally[k]) status_tally[k] = 0;
    endfunction

    // larger means due sooner
    function int urgency(logic [TICK_W-1:0] now, int unsigned idx);
      logic [TICK_W-1:0] passed;
      passed = now - slots[idx].created;
      return int'(passed) - 2 * int'(slots[idx].timeout);
    endfunction

    function void swap_slots(int unsigned a, int unsigned b);
      heap_slot_t held;
      held     = slots[a];
      slots[a] = slots[b];
      slots[b] = held;
    endfunction

    function void climb(logic [TICK_W-1:0] now, int unsigned start_idx);
      int unsigned idx;
      int unsigned parent;
      idx = start_idx;
      while (idx > 0) begin
        parent = (idx - 1) / 2;
        if (urgency(now, idx) <= urgency(now, parent)) break;
        swap_slots(idx, parent);
        idx = parent;
      end
    endfunction

    function void descend(logic [TICK_W-1:0] now, int unsigned start_idx);
      int unsigned idx;
      int unsigned best;
      idx = start_idx;
      forever begin
        best = idx;
        if (2 * idx + 1 < occupancy && urgency(now, 2 * idx + 1) > urgency(now, best)) begin
          best = 2 * idx + 1;
        end
        if (2 * idx + 2 < occupancy && urgency(now, 2 * idx + 2) > urgency(now, best)) begin
          best = 2 * idx + 2;
        end
        if (best == idx) break;
        swap_slots(idx, best);
        idx = best;
      end
    endfunction

    function void note_command(logic op, logic [TICK_W-1:0] now, logic [TMO_W-1:0] tmo,
                               logic [TagBits-1:0] tag);
      answer_t ans;
      ans = '0;
      if (op == OP_ENQ) begin
        if (occupancy >= Capacity) begin
          ans.status = ST_FULL;
        end else if (tmo == '0) begin
          ans.status = ST_ZERO;
        end else begin
          slots[occupancy].timeout = tmo;
          slots[occupancy].created = now;
          slots[occupancy].tag     = tag;
          occupancy++;
          climb(now, occupancy - 1);
          ans.status = ST_ENQ;
        end
      end else begin
        if (occupancy == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          ans.tag     = slots[0].tag;
          ans.timeout = slots[0].timeout;
          ans.created = slots[0].created;
          occupancy--;
          slots[0] = slots[occupancy];
          descend(now, 0);
          ans.status = ST_DEQ;
        end
      end
      ans.count = occupancy[CntW-1:0];
      status_tally[ans.status]++;
      expected_answers.push_back(ans);
    endfunction

    task report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
      mismatches++;
    endtask

    task check_result(answer_t got);
      answer_t want;
      if (expected_answers.size() == 0) begin
        $display("%0t: result strobe with no command pending", $realtime);
        mismatches++;
      end else begin
        want = expected_answers.pop_front();
        if (got.status !== want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.tag !== want.tag)
          report_mismatch("out_tag", 32'(got.tag), 32'(want.tag));
        if (got.timeout !== want.timeout)
          report_mismatch("out_timeout", 32'(got.timeout), 32'(want.timeout));
        if (got.created !== want.created)
          report_mismatch("out_created", 32'(got.created), 32'(want.created));
        if (got.count !== want.count)
          report_mismatch("out_count", 32'(got.count), 32'(want.count));
      end
    endtask
  endclass

  logic                clk_i        = 1'b0;
  logic                rst_ni       = 1'b0;
  logic                start        = 1'b0;
  logic                busy;
  logic                operation_i  = OP_ENQ;
  logic [TICK_W-1:0]   now_ticks_i  = '0;
  logic [TMO_W-1:0]    timeout_us_i = '0;
  logic [TagBits-1:0]  event_tag_i  = '0;
  logic                done_o;
  logic [STATUS_W-1:0] status_o;
  logic [TagBits-1:0]  out_tag_o;
  logic [TMO_W-1:0]    out_timeout_o;
  logic [TICK_W-1:0]   out_created_o;
  logic [CntW-1:0]     out_count_o;

  timer_heap_tracker tracker = new();
  int unsigned       cycle_count = 0;
  bit                idling_on = 1'b1;
  logic [TICK_W-1:0] tick_now = '0;

  timer_event_heap_queue_core #(
    .CAPACITY(Capacity),
    .TAG_BITS(TagBits)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .now_ticks_i  (now_ticks_i),
    .timeout_us_i (timeout_us_i),
    .event_tag_i  (event_tag_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .out_tag_o    (out_tag_o),
    .out_timeout_o(out_timeout_o),
    .out_created_o(out_created_o),
    .out_count_o  (out_count_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
               tracker.expected_answers.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      tracker.check_result('{status_o, out_tag_o, out_timeout_o, out_created_o, out_count_o});
    end
  end

  // one command transfer, with a random pause in front when idling is on
  task automatic issue_command(logic op, logic [TICK_W-1:0] now, logic [TMO_W-1:0] tmo,
                               logic [TagBits-1:0] tag);
    int unsigned gap;
    gap = idling_on ? $urandom_range(0, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start        <= 1'b1;
    operation_i  <= op;
    now_ticks_i  <= now;
    timeout_us_i <= tmo;
    event_tag_i  <= tag;
    do @(posedge clk_i); while (busy);
    tracker.note_command(op, now, tmo, tag);
  endtask

  task automatic random_command(int unsigned enq_pct);
    logic               op;
    logic [TMO_W-1:0]   tmo;
    int unsigned        pick;
    op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
    // timer mostly runs forward, now and then it jumps anywhere
    if ($urandom_range(0, 19) == 0) tick_now = TICK_W'($urandom_range(0, 65535));
    else tick_now = tick_now + TICK_W'($urandom_range(0, 400));
    pick = $urandom_range(0, 19);
    if (pick == 0) tmo = '0;
    else if (pick < 10) tmo = TMO_W'($urandom_range(1, 300));
    else if (pick < 18) tmo = TMO_W'($urandom_range(1, 32767));
    else if (pick == 18) tmo = 15'h7fff;
    else tmo = TMO_W'($urandom_range(16384, 32767));
    issue_command(op, tick_now, tmo, TagBits'($urandom_range(0, 255)));
  endtask

  initial begin
    int unsigned enq_pct;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty, zero timeout, extremes of time, timeout and tag, wrap and ties
    issue_command(OP_DEQ, 16'd0, 15'd0, 8'd0);
    issue_command(OP_ENQ, 16'd0, 15'd0, 8'd255);
    issue_command(OP_ENQ, 16'd0, 15'd1, 8'd0);
    issue_command(OP_ENQ, 16'hffff, 15'h7fff, 8'd255);
    issue_command(OP_ENQ, 16'hffff, 15'd1, 8'd1);
    issue_command(OP_ENQ, 16'd100, 15'd50, 8'd2);
    issue_command(OP_ENQ, 16'd100, 15'd50, 8'd3);
    for (int k = 0; k < 11; k++) begin
      issue_command(OP_ENQ, 16'(100 + 7 * k), 15'(3 * k + 1), 8'(16 + k));
    end
    // full has priority over zero timeout
    issue_command(OP_ENQ, 16'd200, 15'd5, 8'd170);
    issue_command(OP_ENQ, 16'd200, 15'd0, 8'd85);
    issue_command(OP_DEQ, 16'd0, 15'h7fff, 8'd255);
    issue_command(OP_DEQ, 16'hffff, 15'd0, 8'd0);
    issue_command(OP_DEQ, 16'h8000, 15'd1, 8'd1);

    // phases lean toward filling, draining or balance so full and empty recur
    for (int unsigned n = 0; n < RandomCmds; n++) begin
      if (n % PhaseLen == 0) begin
        case ($urandom_range(0, 2))
          0: enq_pct = 80;
          1: enq_pct = 20;
          default: enq_pct = 50;
        endcase
        idling_on = ($urandom_range(0, 3) != 0);
      end
      random_command(enq_pct);
    end

    @(negedge clk_i);
    start <= 1'b0;
    while (tracker.expected_answers.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("covered %0d enqueued, %0d full, %0d zero timeout, %0d dequeued, %0d empty",
             tracker.status_tally[ST_ENQ], tracker.status_tally[ST_FULL],
             tracker.status_tally[ST_ZERO], tracker.status_tally[ST_DEQ],
             tracker.status_tally[ST_EMPTY]);
    $display("%0d mismatches in %0d cycles", tracker.mismatches, cycle_count);
    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
